// ----- rtl/vsfc_pkg.sv -----
`timescale 1ns / 1ps

package vsfc_pkg;

  // Field widths fixed by the interface
  localparam int OPCODE_W  = 2;
  localparam int OFFSET_W  = 16;
  localparam int ROW_W     = 8;
  localparam int BOFF_W    = 12;
  localparam int LINE_W    = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  // Event codes
  localparam logic [OPCODE_W-1:0] OP_HSYNC  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_VSYNC  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SWAP   = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_LOADOF = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_BUF  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_STEP = 1'd1;

  localparam logic [LINE_W-1:0] LINE_MAX = 9'd511;

  typedef struct packed {
    logic fetch_valid;
    logic fetch_buffer;
    logic vblank_pulse;
    logic front_buffer;
  } fetch_meta_t;

  typedef struct packed {
    fetch_meta_t        meta;
    logic [ROW_W-1:0]   row;
    logic [BOFF_W-1:0]  byte_offset;
  } fetch_res_t;

endpackage

// ----- rtl/vsfc_fetch_pipe.sv -----
`timescale 1ns / 1ps

// Row reduction pipeline: u mod HEIGHT by reciprocal multiply, then byte offset.
// Each stage fills when empty or when the one after it moves on.
module vsfc_fetch_pipe #(
  parameter int HEIGHT     = 137,
  parameter int LINE_BYTES = 29,
  parameter int U_W        = 17
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  vsfc_pkg::fetch_meta_t in_meta,
  input  logic [U_W-1:0]        in_u,
  output logic                  out_valid,
  input  logic                  out_stall,
  output vsfc_pkg::fetch_res_t  out_res
);

  // floor(u * M / 2^SHIFT) is exactly floor(u / HEIGHT) for every u below 2^U_W
  localparam int    SHIFT  = U_W + $clog2(HEIGHT + 1);
  localparam longint RECIP = ((longint'(1) << SHIFT) + HEIGHT - 1) / HEIGHT;
  localparam int    M_W    = $clog2(RECIP + 1);
  localparam int    P_W    = U_W + M_W;
  localparam int    LB_W   = $clog2(LINE_BYTES + 1);
  localparam int    BP_W   = (vsfc_pkg::ROW_W + LB_W > vsfc_pkg::BOFF_W) ?
                             vsfc_pkg::ROW_W + LB_W : vsfc_pkg::BOFF_W;

  logic                  vb_r, vc_r, vo_r;
  logic                  rdy_b, rdy_c, rdy_o;
  vsfc_pkg::fetch_meta_t meta_b_r, meta_c_r;
  logic [U_W-1:0]        u_b_r, u_c_r;
  logic [P_W-1:0]        prod_r;
  logic [U_W-1:0]        qh_r;
  logic [U_W-1:0]        quot;
  logic [U_W-1:0]        rem;
  logic [vsfc_pkg::ROW_W-1:0] row;
  logic [BP_W-1:0]       bprod;
  vsfc_pkg::fetch_res_t  res_nxt, res_r;

  assign rdy_o    = ~vo_r | ~out_stall;
  assign rdy_c    = ~vc_r | rdy_o;
  assign rdy_b    = ~vb_r | rdy_c;
  assign in_ready = rdy_b;

  assign quot  = U_W'(prod_r[P_W-1:SHIFT]);
  assign rem   = u_c_r - qh_r;
  assign row   = vsfc_pkg::ROW_W'(rem);
  assign bprod = BP_W'(row) * BP_W'(LINE_BYTES);

  always_comb begin
    res_nxt.meta        = meta_c_r;
    res_nxt.row         = '0;
    res_nxt.byte_offset = '0;
    if (meta_c_r.fetch_valid) begin
      res_nxt.row         = row;
      res_nxt.byte_offset = bprod[vsfc_pkg::BOFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy_b) vb_r <= in_valid;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_o) vo_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && in_valid) begin
      meta_b_r <= in_meta;
      u_b_r    <= in_u;
      prod_r   <= P_W'(in_u) * P_W'(RECIP);
    end
    if (rdy_c && vb_r) begin
      meta_c_r <= meta_b_r;
      u_c_r    <= u_b_r;
      qh_r     <= U_W'(quot * U_W'(HEIGHT));
    end
    if (rdy_o && vc_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_res   = res_r;

endmodule

// ----- rtl/video_scanline_fetch_controller_core.sv -----
`timescale 1ns / 1ps

// Scanline fetch controller for a double-buffered framebuffer scanout.
// Input channel (in_valid / in_stall): one sync or control event per
// transaction, in_opcode selects hsync, vsync, swap request or offset load.
// Every input transaction gives exactly one result transaction on the
// out_ channel (out_valid / out_stall): fetch request, vblank pulse and the
// front buffer after the event.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 enables
// double buffering, index 1 sets the signed scroll step. Write while idle.
// Throughput: one event per cycle while out_stall is low. Each event goes
// through the state register stage, the reciprocal multiply, the
// quotient-times-height multiply and the remainder/byte-offset stage.
// Reset clears the line counter, offset, buffer select, pending swap, both
// registers and all stage valid flags.
// When the receiver stalls, the result holds and empty stages keep filling;
// in_stall rises only once all four stages hold a transaction.
module video_scanline_fetch_controller_core #(
  parameter int FIRST_LINE   = 23,
  parameter int ACTIVE_LINES = 275,
  parameter int LINE_BYTES   = 29
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [vsfc_pkg::OPCODE_W-1:0]         in_opcode,
  input  logic signed [vsfc_pkg::OFFSET_W-1:0]  in_offset_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_fetch_valid,
  output logic                                  out_fetch_buffer,
  output logic [vsfc_pkg::ROW_W-1:0]            out_fetch_row,
  output logic [vsfc_pkg::BOFF_W-1:0]           out_fetch_byte_offset,
  output logic                                  out_vblank_pulse,
  output logic                                  out_front_buffer,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vsfc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vsfc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int HEIGHT = (ACTIVE_LINES - 1) / 2;
  // Multiple of HEIGHT that lifts the most negative row sum to zero or above
  localparam int BIAS   = HEIGHT * ((32768 + HEIGHT - 1) / HEIGHT);
  localparam int U_W    = $clog2(HEIGHT + 32767 + BIAS + 1);
  localparam logic [vsfc_pkg::LINE_W-1:0] FL_LINE = vsfc_pkg::LINE_W'(FIRST_LINE);
  localparam logic [vsfc_pkg::LINE_W-1:0] WE_LINE =
    vsfc_pkg::LINE_W'(FIRST_LINE + ACTIVE_LINES);

  logic                          dbe_r;
  logic [15:0]                   step_r;
  logic [vsfc_pkg::LINE_W-1:0]   line_count_r, line_count_nxt, lc_inc, half;
  logic [15:0]                   voff_r, voff_nxt;
  logic                          front_r, front_nxt;
  logic                          pend_r, pend_nxt;
  logic                          in_acc;
  logic                          va_r, rdy_a, pipe_ready;
  vsfc_pkg::fetch_meta_t         meta_nxt, meta_a_r;
  logic [U_W-1:0]                u_nxt, u_a_r;
  logic                          res_valid;
  vsfc_pkg::fetch_res_t          res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbe_r  <= 1'b0;
      step_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        vsfc_pkg::CFG_DOUBLE_BUF:  dbe_r  <= cfg_data[0];
        vsfc_pkg::CFG_SCROLL_STEP: step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rdy_a    = ~va_r | pipe_ready;
  assign in_stall = ~rdy_a;
  assign in_acc   = in_valid & rdy_a;

  assign lc_inc = (line_count_r != vsfc_pkg::LINE_MAX) ?
                  line_count_r + 9'd1 : line_count_r;
  assign half   = (lc_inc - FL_LINE) >> 1;

  always_comb begin
    line_count_nxt = line_count_r;
    voff_nxt       = voff_r;
    front_nxt      = front_r;
    pend_nxt       = pend_r;
    meta_nxt       = '0;
    u_nxt          = U_W'(half) + U_W'(BIAS) + {{(U_W-16){voff_r[15]}}, voff_r};
    case (in_opcode)
      vsfc_pkg::OP_HSYNC: begin
        line_count_nxt = lc_inc;
        if (lc_inc >= FL_LINE && lc_inc < WE_LINE) begin
          meta_nxt.fetch_valid  = 1'b1;
          meta_nxt.fetch_buffer = dbe_r ? ~front_r : front_r;
        end else if (lc_inc == WE_LINE) begin
          meta_nxt.vblank_pulse = 1'b1;
          if (pend_r && dbe_r) begin
            pend_nxt  = 1'b0;
            front_nxt = ~front_r;
          end
        end
      end
      vsfc_pkg::OP_VSYNC: begin
        line_count_nxt = '0;
        voff_nxt       = voff_r + step_r;
        if (pend_r && dbe_r) begin
          pend_nxt  = 1'b0;
          front_nxt = ~front_r;
        end
      end
      vsfc_pkg::OP_SWAP:   pend_nxt = 1'b1;
      vsfc_pkg::OP_LOADOF: voff_nxt = in_offset_value;
      default: ;
    endcase
    meta_nxt.front_buffer = front_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_count_r <= '0;
      voff_r       <= '0;
      front_r      <= 1'b0;
      pend_r       <= 1'b0;
      va_r         <= 1'b0;
    end else begin
      if (in_acc) begin
        line_count_r <= line_count_nxt;
        voff_r       <= voff_nxt;
        front_r      <= front_nxt;
        pend_r       <= pend_nxt;
      end
      if (rdy_a) va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      meta_a_r <= meta_nxt;
      u_a_r    <= u_nxt;
    end
  end

  vsfc_fetch_pipe #(
    .HEIGHT     (HEIGHT),
    .LINE_BYTES (LINE_BYTES),
    .U_W        (U_W)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (va_r),
    .in_ready  (pipe_ready),
    .in_meta   (meta_a_r),
    .in_u      (u_a_r),
    .out_valid (res_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_valid             = res_valid;
  assign out_fetch_valid       = res.meta.fetch_valid;
  assign out_fetch_buffer      = res.meta.fetch_buffer;
  assign out_fetch_row         = res.row;
  assign out_fetch_byte_offset = res.byte_offset;
  assign out_vblank_pulse      = res.meta.vblank_pulse;
  assign out_front_buffer      = res.meta.front_buffer;

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fetch_valid |-> out_fetch_row < vsfc_pkg::ROW_W'(HEIGHT))
    else $error("fetch row outside buffer height");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fetch_valid |->
      out_fetch_row == '0 && out_fetch_byte_offset == '0 && !out_fetch_buffer)
    else $error("fetch fields not cleared on a non-fetch result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the pipeline can advance");

  a_front_moves_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && front_r != $past(front_r) |-> $past(in_acc))
    else $error("front buffer changed without an accepted transaction");

endmodule
